@@ design/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and helpers for the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // Default number of 4 KiB table pages held in the on-chip store.
  localparam int TABLE_PAGES_DEF   = 8;
  // Entries in one table; fixed by the x86-64 format.
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;

  localparam int PA_W   = 64;
  localparam int VA_W   = 48;
  localparam int BASE_W = 40;
  localparam int WIDX_W = 12;

  // Entry bit positions.
  localparam int BIT_PRESENT = 0;
  localparam int BIT_SIZE    = 7;

  typedef enum logic {
    FUNC_WRITE     = 1'b0,
    FUNC_TRANSLATE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_PRESENT = 2'd1,
    STAT_OUTSIDE     = 2'd2,
    STAT_WRITE_DONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PAGE_4K = 2'd0,
    PAGE_2M = 2'd1,
    PAGE_1G = 2'd2
  } page_kind_t;

  // Walk levels, top table first.
  localparam logic [1:0] LVL_PML4 = 2'd3;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PT   = 2'd0;

  typedef enum logic [1:0] {
    WS_IDLE = 2'd0,
    WS_WALK = 2'd1,
    WS_HOLD = 2'd2
  } walk_state_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    status_t         status;
    logic [1:0]      fault_level;
    page_kind_t      page_kind;
  } result_t;

  // Table index of the virtual address for a given level.
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ design/ptw_store.sv @@
// ----------------------------------------------------------------------------
// ptw_store
// Table word memory: one write port, one registered read port, and a
// clearing pass after reset that zeroes every word, one per cycle.
// ----------------------------------------------------------------------------
module ptw_store #(
  parameter int DEPTH  = ptw_pkg::TABLE_PAGES_DEF * ptw_pkg::ENTRIES_PER_TABLE,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [ptw_pkg::PA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [ptw_pkg::PA_W-1:0] rd_data,
  output logic                     clear_busy
);

  logic [ptw_pkg::PA_W-1:0] mem [0:DEPTH-1];
  logic [ptw_pkg::PA_W-1:0] rd_data_r;
  logic                     clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_busy = clr_active_r;

endmodule

@@ design/ptw_bound.sv @@
// ----------------------------------------------------------------------------
// ptw_bound
// Shared range unit: maps a table address onto a store page, or flags it as
// lying outside the store window.
// ----------------------------------------------------------------------------
module ptw_bound #(
  parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF,
  parameter int PAGE_W      = $clog2(TABLE_PAGES)
) (
  input  logic [ptw_pkg::PA_W-1:0]   table_addr,
  input  logic [ptw_pkg::BASE_W-1:0] base_page,
  output logic                       in_store,
  output logic [PAGE_W-1:0]          rel_page
);

  localparam int PN_W = ptw_pkg::PA_W - 12;

  logic [PN_W:0] diff;

  // The top bit of the difference is the borrow: page below the base.
  assign diff     = {1'b0, table_addr[ptw_pkg::PA_W-1:12]}
                  - {{(PN_W + 1 - ptw_pkg::BASE_W){1'b0}}, base_page};
  assign in_store = !diff[PN_W] && (diff[PN_W-1:0] < PN_W'(TABLE_PAGES));
  assign rel_page = diff[PAGE_W-1:0];

endmodule

@@ design/ptw_walk.sv @@
// ----------------------------------------------------------------------------
// ptw_walk
// Walk sequencer: takes one transaction at a time, issues one table read per
// level through the shared range unit and forms the result.
// ----------------------------------------------------------------------------
module ptw_walk #(
  parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF,
  parameter int PAGE_W      = $clog2(TABLE_PAGES),
  parameter int ADDR_W      = PAGE_W + ptw_pkg::IDX_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [ptw_pkg::WIDX_W-1:0] in_word_index,
  input  logic [ptw_pkg::PA_W-1:0]   in_root_address,
  input  logic [ptw_pkg::VA_W-1:0]   in_vaddr,
  input  logic [ptw_pkg::BASE_W-1:0] base_page,
  input  logic                       clear_busy,
  input  logic                       out_free,
  output logic                       res_valid,
  output ptw_pkg::result_t           res,
  output logic                       mem_we,
  output logic [ADDR_W-1:0]          mem_waddr,
  output logic                       mem_re,
  output logic [ADDR_W-1:0]          mem_raddr,
  input  logic [ptw_pkg::PA_W-1:0]   mem_rdata
);

  localparam int DEPTH = TABLE_PAGES * ptw_pkg::ENTRIES_PER_TABLE;

  ptw_pkg::walk_state_t     state_r, state_nxt;
  logic [1:0]               lvl_r, lvl_nxt;
  logic [ptw_pkg::VA_W-1:0] va_r, va_nxt;
  ptw_pkg::result_t         res_r, res_nxt;

  logic                       accept;
  logic [ptw_pkg::PA_W-1:0]   bnd_addr;
  logic                       bnd_in_store;
  logic [PAGE_W-1:0]          bnd_rel;
  logic [ptw_pkg::IDX_W-1:0]  rd_idx;
  logic                       done_now;
  ptw_pkg::result_t           result_now;
  logic [1:0]                 lvl_down;
  logic                       size_bit;

  ptw_bound #(
    .TABLE_PAGES(TABLE_PAGES),
    .PAGE_W     (PAGE_W)
  ) u_bound (
    .table_addr(bnd_addr),
    .base_page (base_page),
    .in_store  (bnd_in_store),
    .rel_page  (bnd_rel)
  );

  assign in_ready  = (state_r == ptw_pkg::WS_IDLE) && !clear_busy;
  assign accept    = in_valid && in_ready;
  assign lvl_down  = lvl_r - 2'd1;
  assign size_bit  = mem_rdata[ptw_pkg::BIT_SIZE];
  assign mem_waddr = ADDR_W'(in_word_index);
  assign mem_raddr = {bnd_rel, rd_idx};

  always_comb begin
    state_nxt  = state_r;
    lvl_nxt    = lvl_r;
    va_nxt     = va_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    res_valid  = 1'b0;
    res        = res_r;
    done_now   = 1'b0;
    result_now = '{phys_addr: '0, status: ptw_pkg::STAT_OK,
                   fault_level: ptw_pkg::LVL_PT, page_kind: ptw_pkg::PAGE_4K};
    bnd_addr   = in_root_address;
    rd_idx     = ptw_pkg::va_index(in_vaddr, ptw_pkg::LVL_PML4);

    case (state_r)
      ptw_pkg::WS_IDLE: begin
        if (accept) begin
          if (in_func == ptw_pkg::FUNC_WRITE) begin
            // Writes past the end of the store are dropped but still answered.
            mem_we            = ({20'd0, in_word_index} < 32'(DEPTH));
            done_now          = 1'b1;
            result_now.status = ptw_pkg::STAT_WRITE_DONE;
          end else begin
            va_nxt  = in_vaddr;
            lvl_nxt = ptw_pkg::LVL_PML4;
            if (bnd_in_store) begin
              mem_re    = 1'b1;
              state_nxt = ptw_pkg::WS_WALK;
            end else begin
              done_now               = 1'b1;
              result_now.status      = ptw_pkg::STAT_OUTSIDE;
              result_now.fault_level = ptw_pkg::LVL_PML4;
            end
          end
        end
      end

      ptw_pkg::WS_WALK: begin
        // The entry of level lvl_r is on the read port; the next table's
        // address goes through the range unit in the same cycle.
        bnd_addr = mem_rdata;
        rd_idx   = ptw_pkg::va_index(va_r, lvl_down);
        done_now = 1'b1;
        if (!mem_rdata[ptw_pkg::BIT_PRESENT]) begin
          result_now.status      = ptw_pkg::STAT_NOT_PRESENT;
          result_now.fault_level = lvl_r;
        end else if (lvl_r == ptw_pkg::LVL_PDPT && size_bit) begin
          result_now.phys_addr = {mem_rdata[63:30], va_r[29:0]};
          result_now.page_kind = ptw_pkg::PAGE_1G;
        end else if (lvl_r == ptw_pkg::LVL_PD && size_bit) begin
          result_now.phys_addr = {mem_rdata[63:21], va_r[20:0]};
          result_now.page_kind = ptw_pkg::PAGE_2M;
        end else if (lvl_r == ptw_pkg::LVL_PT) begin
          result_now.phys_addr = {mem_rdata[63:12], va_r[11:0]};
        end else if (!bnd_in_store) begin
          result_now.status      = ptw_pkg::STAT_OUTSIDE;
          result_now.fault_level = lvl_down;
        end else begin
          done_now = 1'b0;
          mem_re   = 1'b1;
          lvl_nxt  = lvl_down;
        end
      end

      ptw_pkg::WS_HOLD: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = ptw_pkg::WS_IDLE;
        end
      end

      default: begin
        state_nxt = ptw_pkg::WS_IDLE;
      end
    endcase

    if (done_now) begin
      if (out_free) begin
        res_valid = 1'b1;
        res       = result_now;
        state_nxt = ptw_pkg::WS_IDLE;
      end else begin
        res_nxt   = result_now;
        state_nxt = ptw_pkg::WS_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptw_pkg::WS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    va_r  <= va_nxt;
    res_r <= res_nxt;
  end

endmodule

@@ design/four_level_page_table_walker.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level x86-64 page table walk over an on-chip store of table words.
//
//   Channel | Direction | Ports                          | Contents
//   --------+-----------+--------------------------------+------------------------
//   in      | input     | in_tvalid/tready/tdata/tuser   | table write or translate
//   out     | output    | out_tvalid/tready/tdata/tuser  | translation or status
//   cfg     | input     | cfg_wr_en/cfg_wr_data          | store base page number
//
// A write transaction is done in its accepting cycle. A translate issues one table
// read per level walked, the first in its accepting cycle, one at a time through the
// single store read port. After reset a clearing pass zeroes all TABLE_PAGES * 512
// store words (4096 at the default size); no input is taken until it ends. Results
// go through an output register, so the next transaction is taken while a result
// waits; a second result then holds the walker until the first one is taken.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
  parameter int TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata, low bit up: word_index[11:0], write_data[75:12],
  // root_address[139:76], vaddr[187:140], zero fill[191:188]
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [191:0]               in_tdata,
  // in_tuser: func
  input  logic                       in_tuser,
  // out_tdata, low bit up: paddr[63:0], fault_level[65:64],
  // page_kind[67:66], zero fill[71:68]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [71:0]                out_tdata,
  // out_tuser: status
  output logic [1:0]                 out_tuser,
  input  logic                       cfg_wr_en,
  input  logic [ptw_pkg::BASE_W-1:0] cfg_wr_data
);

  localparam int DEPTH  = TABLE_PAGES * ptw_pkg::ENTRIES_PER_TABLE;
  localparam int PAGE_W = $clog2(TABLE_PAGES);
  localparam int ADDR_W = PAGE_W + ptw_pkg::IDX_W;

  logic [ptw_pkg::BASE_W-1:0] base_r;
  logic                       out_valid_r, out_valid_nxt;
  ptw_pkg::result_t           out_res_r;

  logic                     clear_busy;
  logic                     out_free;
  logic                     res_valid;
  ptw_pkg::result_t         res;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [ptw_pkg::PA_W-1:0] mem_rdata;

  ptw_store #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (in_tdata[75:12]),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data   (mem_rdata),
    .clear_busy(clear_busy)
  );

  ptw_walk #(
    .TABLE_PAGES(TABLE_PAGES),
    .PAGE_W     (PAGE_W),
    .ADDR_W     (ADDR_W)
  ) u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_func        (in_tuser),
    .in_word_index  (in_tdata[11:0]),
    .in_root_address(in_tdata[139:76]),
    .in_vaddr       (in_tdata[187:140]),
    .base_page      (base_r),
    .clear_busy     (clear_busy),
    .out_free       (out_free),
    .res_valid      (res_valid),
    .res            (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r.page_kind, out_res_r.fault_level,
                       out_res_r.phys_addr};
  assign out_tuser  = out_res_r.status;

  // A result is only handed over when the output register can take it.
  a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result produced while output register is occupied");

  // The clearing pass owns the store; the walker must not touch it.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> (!mem_we && !mem_re))
    else $error("store access during clearing pass");

  // A write transaction is answered in the next cycle when the output is free.
  a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ptw_pkg::FUNC_WRITE) && out_free)
      |=> (out_tvalid && (out_tuser == ptw_pkg::STAT_WRITE_DONE)))
    else $error("write transaction not answered");

  // Fault results never carry an address.
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == ptw_pkg::STAT_NOT_PRESENT
                   || res.status == ptw_pkg::STAT_OUTSIDE))
      |-> (res.phys_addr == '0 && res.page_kind == ptw_pkg::PAGE_4K))
    else $error("fault result with nonzero address or page kind");

endmodule
